// ===== rtl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// shared constants, octant codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package mlr_pkg;

    // tile coordinate width
    localparam int COORD_BITS = 6;
    // decision variable width: covers -2*a .. 2*a plus sign
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int OCT_BITS   = 3;

    // octant codes, counterclockwise from +x, shallow/steep split
    localparam logic [OCT_BITS-1:0] OCT_0 = 3'd0;
    localparam logic [OCT_BITS-1:0] OCT_1 = 3'd1;
    localparam logic [OCT_BITS-1:0] OCT_2 = 3'd2;
    localparam logic [OCT_BITS-1:0] OCT_3 = 3'd3;
    localparam logic [OCT_BITS-1:0] OCT_4 = 3'd4;
    localparam logic [OCT_BITS-1:0] OCT_5 = 3'd5;
    localparam logic [OCT_BITS-1:0] OCT_6 = 3'd6;
    localparam logic [OCT_BITS-1:0] OCT_7 = 3'd7;

    typedef logic [COORD_BITS-1:0] t_coord;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture endpoints
        logic setup;  // derive deltas, octant and initial decision
        logic step;   // advance one pixel
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;   // current pixel is the end point
    } t_stat;

endpackage

// ===== rtl/mlr_seg_if.sv =====
// ----------------------------------------------------------------------------
// mlr_seg_if
// segment request channel: two endpoints with valid/ready
// ----------------------------------------------------------------------------
interface mlr_seg_if;
    logic                 valid;
    logic                 ready;
    mlr_pkg::t_coord      start_x;
    mlr_pkg::t_coord      start_y;
    mlr_pkg::t_coord      end_x;
    mlr_pkg::t_coord      end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

// ===== rtl/mlr_pix_if.sv =====
// ----------------------------------------------------------------------------
// mlr_pix_if
// pixel request channel: coordinates, octant and last flag with valid/ready
// ----------------------------------------------------------------------------
interface mlr_pix_if;
    logic                              valid;
    logic                              ready;
    mlr_pkg::t_coord                   pixel_x;
    mlr_pkg::t_coord                   pixel_y;
    logic [mlr_pkg::OCT_BITS-1:0]      octant;
    logic                              last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output octant, output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input octant, input last_pixel, output ready);
endinterface

// ===== rtl/mlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlr_ctrl
// sequencer: idle, setup, walk; drives channel handshakes and datapath commands
// ----------------------------------------------------------------------------
module mlr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  mlr_pkg::t_stat i_stat,
    output mlr_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_out_ready && i_stat.last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_RUN);

    assign o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.setup = (r_state == ST_SETUP);
    assign o_cmd.step  = (r_state == ST_RUN) && i_out_ready && !i_stat.last;

endmodule

// ===== rtl/mlr_datapath.sv =====
// ----------------------------------------------------------------------------
// mlr_datapath
// endpoint registers, octant classification and midpoint decision walk
// ----------------------------------------------------------------------------
module mlr_datapath (
    input  logic                          i_clk,
    input  mlr_pkg::t_cmd                 i_cmd,
    input  mlr_pkg::t_coord               i_start_x,
    input  mlr_pkg::t_coord               i_start_y,
    input  mlr_pkg::t_coord               i_end_x,
    input  mlr_pkg::t_coord               i_end_y,
    output mlr_pkg::t_stat                o_stat,
    output mlr_pkg::t_coord               o_pixel_x,
    output mlr_pkg::t_coord               o_pixel_y,
    output logic [mlr_pkg::OCT_BITS-1:0]  o_octant
);

    localparam int W  = mlr_pkg::COORD_BITS;
    localparam int DW = mlr_pkg::DEC_BITS;

    // captured endpoints
    mlr_pkg::t_coord r_x0, r_y0, r_x1, r_y1;

    // walk state
    mlr_pkg::t_coord                r_x, r_y;
    mlr_pkg::t_coord                r_cnt;
    logic signed [DW-1:0]           r_d;
    logic signed [DW-1:0]           r_inc_ax;
    logic signed [DW-1:0]           r_inc_dg;
    logic                           r_steep;
    logic                           r_neg_x;
    logic                           r_neg_y;
    logic [mlr_pkg::OCT_BITS-1:0]   r_oct;

    // setup terms
    logic [W:0]                     w_dx, w_dy;
    logic [W:0]                     w_ndx, w_ndy;
    logic                           w_neg_x, w_neg_y;
    mlr_pkg::t_coord                w_adx, w_ady;
    logic                           w_steep;
    mlr_pkg::t_coord                w_a, w_b;
    logic signed [DW-1:0]           w_a2, w_b2, w_a1;
    logic [mlr_pkg::OCT_BITS-1:0]   w_oct;

    // step terms
    mlr_pkg::t_coord                w_x_step, w_y_step;

    assign w_dx    = {1'b0, r_x1} - {1'b0, r_x0};
    assign w_dy    = {1'b0, r_y1} - {1'b0, r_y0};
    assign w_ndx   = '0 - w_dx;
    assign w_ndy   = '0 - w_dy;
    assign w_neg_x = w_dx[W];
    assign w_neg_y = w_dy[W];
    assign w_adx   = w_neg_x ? w_ndx[W-1:0] : w_dx[W-1:0];
    assign w_ady   = w_neg_y ? w_ndy[W-1:0] : w_dy[W-1:0];
    assign w_steep = (w_ady > w_adx);
    assign w_a     = w_steep ? w_ady : w_adx;
    assign w_b     = w_steep ? w_adx : w_ady;
    assign w_a1    = $signed({3'b000, w_a});
    assign w_a2    = $signed({2'b00, w_a, 1'b0});
    assign w_b2    = $signed({2'b00, w_b, 1'b0});

    always_comb begin
        if (!w_steep) begin
            if (!w_neg_x) w_oct = w_neg_y ? mlr_pkg::OCT_7 : mlr_pkg::OCT_0;
            else          w_oct = w_neg_y ? mlr_pkg::OCT_4 : mlr_pkg::OCT_3;
        end else begin
            if (!w_neg_x) w_oct = w_neg_y ? mlr_pkg::OCT_6 : mlr_pkg::OCT_1;
            else          w_oct = w_neg_y ? mlr_pkg::OCT_5 : mlr_pkg::OCT_2;
        end
    end

    assign w_x_step = r_neg_x ? (r_x - 1'b1) : (r_x + 1'b1);
    assign w_y_step = r_neg_y ? (r_y - 1'b1) : (r_y + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_start_x;
            r_y0 <= i_start_y;
            r_x1 <= i_end_x;
            r_y1 <= i_end_y;
        end
        if (i_cmd.setup) begin
            r_x      <= r_x0;
            r_y      <= r_y0;
            r_cnt    <= w_a;
            r_d      <= w_b2 - w_a1;
            r_inc_ax <= w_b2;
            r_inc_dg <= w_b2 - w_a2;
            r_steep  <= w_steep;
            r_neg_x  <= w_neg_x;
            r_neg_y  <= w_neg_y;
            r_oct    <= w_oct;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_d[DW-1]) begin
                // axis step on the major axis only
                if (r_steep) r_y <= w_y_step;
                else         r_x <= w_x_step;
                r_d <= r_d + r_inc_ax;
            end else begin
                r_x <= w_x_step;
                r_y <= w_y_step;
                r_d <= r_d + r_inc_dg;
            end
        end
    end

    assign o_stat.last = (r_cnt == '0);
    assign o_pixel_x   = r_x;
    assign o_pixel_y   = r_y;
    assign o_octant    = r_oct;

endmodule

// ===== rtl/midpoint_line_rasterizer.sv =====
// a taken segment passes the setup state, which registers deltas, octant and decision, then
//   the run state offers pixels; the next segment is taken only once the last pixel is taken;
//   one pixel per cycle while o_pix.ready holds, from the single decision/step register set
// a zero-length segment gives one pixel; a full-tile segment gives 64
// reset: synchronous active low, returns the sequencer to idle; no pixel pending
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// eight-octant midpoint line walker for a 64x64 tile: one segment in, one
// pixel request per pixel out, last pixel flagged, octant on every pixel
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlr_seg_if.sink    i_seg,
    mlr_pix_if.source  o_pix
);

    // command and status between sequencer and datapath
    mlr_pkg::t_cmd  w_cmd;
    mlr_pkg::t_stat w_stat;

    // sequencer: idle takes a segment, setup derives deltas, run walks pixels
    mlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_seg.valid),
        .i_out_ready (o_pix.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_seg.ready),
        .o_out_valid (o_pix.valid)
    );

    // datapath: current pixel lives in registers and feeds the output directly,
    // so a stalled pixel request simply holds until taken
    mlr_datapath u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_start_x (i_seg.start_x),
        .i_start_y (i_seg.start_y),
        .i_end_x   (i_seg.end_x),
        .i_end_y   (i_seg.end_y),
        .o_stat    (w_stat),
        .o_pixel_x (o_pix.pixel_x),
        .o_pixel_y (o_pix.pixel_y),
        .o_octant  (o_pix.octant)
    );

    // the remaining-step counter reaching zero marks the end point
    assign o_pix.last_pixel = w_stat.last;

`ifndef ASSERT_OFF
    // never take a segment while pixels are still being offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_seg.ready && o_pix.valid))
        else $error("segment accepted while pixels pending");

    // a taken segment always leads to pixel output, never straight back to idle
    a_seg_to_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |=> (!i_seg.ready && !o_pix.valid)
        ##1 o_pix.valid)
        else $error("segment request not followed by pixels");

    // taking the final pixel frees the block for the next segment
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready && o_pix.last_pixel) |=> i_seg.ready)
        else $error("not idle after last pixel");

    // every step moves the pixel, since the major axis always advances
    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready && !o_pix.last_pixel) |=>
        (o_pix.valid && (o_pix.pixel_x != $past(o_pix.pixel_x) ||
                         o_pix.pixel_y != $past(o_pix.pixel_y))))
        else $error("pixel did not advance");
`endif

endmodule
